/* src/normalize_vector_3d_defines.svh */
// Assertion macros used by the port checker of the vector normalizer.
`ifndef NORMALIZE_VECTOR_3D_DEFINES_SVH
`define NORMALIZE_VECTOR_3D_DEFINES_SVH

// Checks that an implication holds at every clock edge outside reset.
`define NV3_ASSERT_IMPL(lbl, clk_sig, rst_n_sig, cond, expr, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (cond) |-> (expr)) \
		else $error(msg);

// Checks that a condition is never seen at a clock edge outside reset.
`define NV3_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(expr)) \
		else $error(msg);

`endif

/* src/nv3_pkg.sv */
// Package with the shared constants of the vector normalizer.
`timescale 1ns / 1ps
`default_nettype none
package nv3_pkg;
	localparam int COORD_BITS_DEF = 32;
	localparam int Q_BITS = 32;
	localparam int LANES = 3;
endpackage
`default_nettype wire

/* src/normalize_vector_3d.sv */
// Top level of the 3D vector normalizer.
// A vector transfer happens at a clock edge with start high and busy low.
// The three signed Q16.16 components enter on comp_x, comp_y and comp_z.
// The block takes a new vector in every cycle, so busy is always low.
// Each result is shown for one cycle with done high and carries the
// normalized components unit_x, unit_y, unit_z in signed Q1.30, the
// length in unsigned Q16.16 on magnitude, and zero_vector for a zero length.
// A vector passes the registers for absolute values, squares and their sum,
// then the square root chain, whose cells each give one root bit, the
// division chain, whose cells each give one quotient bit, and one output register.
// Throughput is one vector per cycle, set by the chains of cells that each
// hand their partial results to the next cell in every cycle.
// Results leave in the order of their transfers; the receiver cannot stall.
// Reset clears the valid bits of all stages, so no result appears until
// new vectors arrive.
`timescale 1ns / 1ps
`default_nettype none
module normalize_vector_3d import nv3_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [COORD_BITS-1:0]  comp_x,
	input  wire logic signed [COORD_BITS-1:0]  comp_y,
	input  wire logic signed [COORD_BITS-1:0]  comp_z,
	output logic                               done,
	output logic signed      [Q_BITS-1:0]      unit_x,
	output logic signed      [Q_BITS-1:0]      unit_y,
	output logic signed      [Q_BITS-1:0]      unit_z,
	output logic             [Q_BITS-1:0]      magnitude,
	output logic                               zero_vector
);
	localparam int CB  = COORD_BITS;
	localparam int SW  = 2 * CB;
	localparam int PWS = LANES * CB + LANES;
	localparam int PWD = LANES + Q_BITS + 1;

	logic [LANES-1:0][CB-1:0] comp_w;
	logic [LANES-1:0][CB-1:0] mag_w;
	logic [LANES-1:0]         neg_w;

	logic                     vld_s1, vld_s2, vld_s3;
	logic [LANES-1:0][CB-1:0] mag_s1, mag_s2, mag_s3;
	logic [LANES-1:0]         neg_s1, neg_s2, neg_s3;
	logic [LANES-1:0][SW-1:0] sq_s2;
	logic [SW-1:0]            sum_s3;

	logic                     sv   [CB+1];
	logic [SW-1:0]            srad [CB+1];
	logic [CB+1:0]            srem [CB+1];
	logic [CB-1:0]            sroot[CB+1];
	logic [PWS-1:0]           spl  [CB+1];

	logic                         dv  [Q_BITS+1];
	logic [LANES-1:0][CB-1:0]     dr  [Q_BITS+1];
	logic [LANES-1:0][Q_BITS-1:0] dq  [Q_BITS+1];
	logic [LANES-1:0][1:0]        dnb [Q_BITS+1];
	logic [CB-1:0]                dlen[Q_BITS+1];
	logic [PWD-1:0]               dpl [Q_BITS+1];

	logic [CB-1:0]            len_w;
	logic [LANES-1:0][CB-1:0] smag_w;
	logic [LANES-1:0]         sneg_w;
	logic [CB+Q_BITS-1:0]     len_ext;
	logic [Q_BITS-1:0]        len_sat;
	logic                     zero_w;

	logic [LANES-1:0][Q_BITS-1:0] q_end;
	logic [LANES-1:0]             neg_end;
	logic [LANES-1:0][Q_BITS-1:0] unit_w;
	logic                         zero_end;

	logic                         done_q;
	logic [LANES-1:0][Q_BITS-1:0] unit_q;
	logic [Q_BITS-1:0]            magnitude_q;
	logic                         zero_q;

	assign busy = 1'b0;

	always_comb begin
		comp_w[0] = comp_x;
		comp_w[1] = comp_y;
		comp_w[2] = comp_z;
		for (int i = 0; i < LANES; i++) begin
			neg_w[i] = comp_w[i][CB-1];
			mag_w[i] = neg_w[i] ? (~comp_w[i] + 1'b1) : comp_w[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag_w;
		neg_s1 <= neg_w;
		for (int i = 0; i < LANES; i++) begin
			sq_s2[i] <= {{CB{1'b0}}, mag_s1[i]} * {{CB{1'b0}}, mag_s1[i]};
		end
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
		sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;
	end

	assign sv[0]    = vld_s3;
	assign srad[0]  = sum_s3;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign spl[0]   = {neg_s3, mag_s3};

	for (genvar k = 0; k < CB; k++) begin : g_sqrt
		nv3_sqrt_cell #(
			.CB(CB),
			.PW(PWS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (sv[k]),
			.rad_in (srad[k]),
			.rem_in (srem[k]),
			.root_in(sroot[k]),
			.pl_in  (spl[k]),
			.vld_q  (sv[k+1]),
			.rad_q  (srad[k+1]),
			.rem_q  (srem[k+1]),
			.root_q (sroot[k+1]),
			.pl_q   (spl[k+1])
		);
	end

	always_comb begin
		len_w   = sroot[CB];
		smag_w  = spl[CB][LANES*CB-1:0];
		sneg_w  = spl[CB][PWS-1 -: LANES];
		zero_w  = (len_w == '0);
		len_ext = {{Q_BITS{1'b0}}, len_w};
		len_sat = (len_ext > {{CB{1'b0}}, {Q_BITS{1'b1}}}) ? {Q_BITS{1'b1}}
			: len_ext[Q_BITS-1:0];
		for (int i = 0; i < LANES; i++) begin
			dr[0][i]  = {2'b00, smag_w[i][CB-1:2]};
			dnb[0][i] = smag_w[i][1:0];
			dq[0][i]  = '0;
		end
	end

	assign dv[0]   = sv[CB];
	assign dlen[0] = len_w;
	assign dpl[0]  = {zero_w, len_sat, sneg_w};

	for (genvar k = 0; k < Q_BITS; k++) begin : g_div
		nv3_div_cell #(
			.CB(CB),
			.PW(PWD)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.vld_in(dv[k]),
			.r_in  (dr[k]),
			.q_in  (dq[k]),
			.nb_in (dnb[k]),
			.len_in(dlen[k]),
			.pl_in (dpl[k]),
			.vld_q (dv[k+1]),
			.r_q   (dr[k+1]),
			.q_q   (dq[k+1]),
			.nb_q  (dnb[k+1]),
			.len_q (dlen[k+1]),
			.pl_q  (dpl[k+1])
		);
	end

	always_comb begin
		q_end    = dq[Q_BITS];
		neg_end  = dpl[Q_BITS][LANES-1:0];
		zero_end = dpl[Q_BITS][PWD-1];
		for (int i = 0; i < LANES; i++) begin
			if (zero_end) begin
				unit_w[i] = '0;
			end else if (neg_end[i]) begin
				unit_w[i] = ~q_end[i] + 1'b1;
			end else begin
				unit_w[i] = q_end[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv[Q_BITS];
		end
	end

	always_ff @(posedge clk) begin
		unit_q      <= unit_w;
		magnitude_q <= dpl[Q_BITS][LANES +: Q_BITS];
		zero_q      <= zero_end;
	end

	assign done        = done_q;
	assign unit_x      = unit_q[0];
	assign unit_y      = unit_q[1];
	assign unit_z      = unit_q[2];
	assign magnitude   = magnitude_q;
	assign zero_vector = zero_q;
	// dlen and dr of the last cell are not needed past the chain.
	logic unused_w;
	assign unused_w = ^{dlen[Q_BITS], dr[Q_BITS], dnb[Q_BITS]};
endmodule
`default_nettype wire

/* src/nv3_sqrt_cell.sv */
// One cell of the square root chain, producing one bit of the root per cycle.
`timescale 1ns / 1ps
`default_nettype none
module nv3_sqrt_cell import nv3_pkg::*; #(
	parameter int CB = COORD_BITS_DEF,
	parameter int PW = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld_in,
	input  wire logic [2*CB-1:0]   rad_in,
	input  wire logic [CB+1:0]     rem_in,
	input  wire logic [CB-1:0]     root_in,
	input  wire logic [PW-1:0]     pl_in,
	output logic                   vld_q,
	output logic      [2*CB-1:0]   rad_q,
	output logic      [CB+1:0]     rem_q,
	output logic      [CB-1:0]     root_q,
	output logic      [PW-1:0]     pl_q
);
	logic [CB+3:0] cur;
	logic [CB+3:0] sub;
	logic [CB+3:0] trial;
	logic          ok;

	always_comb begin
		cur   = {rem_in, rad_in[2*CB-1 -: 2]};
		sub   = {2'b00, root_in, 2'b01};
		trial = cur - sub;
		ok    = (cur >= sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= {rad_in[2*CB-3:0], 2'b00};
		rem_q  <= ok ? trial[CB+1:0] : cur[CB+1:0];
		root_q <= {root_in[CB-2:0], ok};
		pl_q   <= pl_in;
	end
endmodule
`default_nettype wire

/* src/nv3_div_cell.sv */
// One cell of the division chain, producing one quotient bit of each lane per cycle.
`timescale 1ns / 1ps
`default_nettype none
module nv3_div_cell import nv3_pkg::*; #(
	parameter int CB = COORD_BITS_DEF,
	parameter int PW = 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           vld_in,
	input  wire logic [LANES-1:0][CB-1:0]       r_in,
	input  wire logic [LANES-1:0][Q_BITS-1:0]   q_in,
	input  wire logic [LANES-1:0][1:0]          nb_in,
	input  wire logic [CB-1:0]                  len_in,
	input  wire logic [PW-1:0]                  pl_in,
	output logic                                vld_q,
	output logic      [LANES-1:0][CB-1:0]       r_q,
	output logic      [LANES-1:0][Q_BITS-1:0]   q_q,
	output logic      [LANES-1:0][1:0]          nb_q,
	output logic      [CB-1:0]                  len_q,
	output logic      [PW-1:0]                  pl_q
);
	logic [LANES-1:0][CB:0]       rx;
	logic [LANES-1:0][CB:0]       diff;
	logic [LANES-1:0]             ge;
	logic [LANES-1:0][CB-1:0]     r_nx;
	logic [LANES-1:0][Q_BITS-1:0] q_nx;
	logic [LANES-1:0][1:0]        nb_nx;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			rx[i]    = {r_in[i], nb_in[i][1]};
			diff[i]  = rx[i] - {1'b0, len_in};
			ge[i]    = (rx[i] >= {1'b0, len_in});
			r_nx[i]  = ge[i] ? diff[i][CB-1:0] : rx[i][CB-1:0];
			q_nx[i]  = {q_in[i][Q_BITS-2:0], ge[i]};
			nb_nx[i] = {nb_in[i][0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		r_q   <= r_nx;
		q_q   <= q_nx;
		nb_q  <= nb_nx;
		len_q <= len_in;
		pl_q  <= pl_in;
	end
endmodule
`default_nettype wire

/* src/nv3_checker.sv */
// Port checker for the vector normalizer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "normalize_vector_3d_defines.svh"
module nv3_checker import nv3_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic                     done,
	input wire logic signed [Q_BITS-1:0] unit_x,
	input wire logic signed [Q_BITS-1:0] unit_y,
	input wire logic signed [Q_BITS-1:0] unit_z,
	input wire logic        [Q_BITS-1:0] magnitude,
	input wire logic                     zero_vector
);
	localparam int LAT = COORD_BITS + 36;

	`NV3_ASSERT_NEVER(a_never_busy, clk, arst_n, busy, "busy was raised")
	`NV3_ASSERT_IMPL(a_done_follows_start, clk, arst_n, done, $past(start, LAT),
		"result without a matching transfer")
	`NV3_ASSERT_IMPL(a_zero_outputs, clk, arst_n, done && zero_vector,
		(unit_x == '0) && (unit_y == '0) && (unit_z == '0) && (magnitude == '0),
		"zero vector with nonzero outputs")
	`NV3_ASSERT_IMPL(a_nonzero_length, clk, arst_n, done && !zero_vector,
		magnitude != '0, "nonzero vector with zero length")
endmodule

bind normalize_vector_3d nv3_checker #(
	.COORD_BITS(COORD_BITS)
) u_nv3_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.unit_x     (unit_x),
	.unit_y     (unit_y),
	.unit_z     (unit_z),
	.magnitude  (magnitude),
	.zero_vector(zero_vector)
);
`default_nettype wire

/* tb/normalize_vector_3d_checker.sv */
// Checker that predicts and compares the results of the vector normalizer.
`timescale 1ns / 1ps
module normalize_vector_3d_checker import nv3_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      busy,
	input  wire logic signed [31:0]        comp_x,
	input  wire logic signed [31:0]        comp_y,
	input  wire logic signed [31:0]        comp_z,
	input  wire logic                      done,
	input  wire logic signed [Q_BITS-1:0]  unit_x,
	input  wire logic signed [Q_BITS-1:0]  unit_y,
	input  wire logic signed [Q_BITS-1:0]  unit_z,
	input  wire logic        [Q_BITS-1:0]  magnitude,
	input  wire logic                      zero_vector,
	output int                             fail_count,
	output int                             pending_count
);
	typedef struct packed {
		logic [31:0] ux;
		logic [31:0] uy;
		logic [31:0] uz;
		logic [31:0] mag;
		logic        zero;
	} unit_result_t;

	unit_result_t expected_units[$];

	function automatic logic [63:0] isqrt(logic [127:0] s);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (128'(t) * 128'(t) <= s)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [31:0] scale_comp(logic signed [31:0] c, logic [63:0] len);
		logic [63:0] a;
		logic [127:0] q;
		a = c[31] ? 64'(-33'(c)) : 64'(c);
		q = (128'(a) << 30) / 128'(len);
		return c[31] ? -q[31:0] : q[31:0];
	endfunction

	function automatic unit_result_t normalize(logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] z);
		unit_result_t r;
		logic [127:0] sum;
		logic [63:0] len;
		sum = 128'(64'(x) * 64'(x)) + 128'(64'(y) * 64'(y)) + 128'(64'(z) * 64'(z));
		len = isqrt(sum);
		r = '0;
		if (len == 0) begin
			r.zero = 1'b1;
		end else begin
			r.ux = scale_comp(x, len);
			r.uy = scale_comp(y, len);
			r.uz = scale_comp(z, len);
			r.mag = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
		end
		return r;
	endfunction

	assign pending_count = expected_units.size();

	always @(posedge clk or negedge arst_n) begin
		unit_result_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (start && !busy)
				expected_units.push_back(normalize(comp_x, comp_y, comp_z));
			if (done) begin
				if (expected_units.size() == 0) begin
					$error("Result transfer with no vector outstanding.");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_units.pop_front();
					if (unit_x !== e.ux || unit_y !== e.uy || unit_z !== e.uz
						|| magnitude !== e.mag || zero_vector !== e.zero) begin
						if (unit_x !== e.ux)
							$error("unit_x expected %h actual %h", e.ux, unit_x);
						if (unit_y !== e.uy)
							$error("unit_y expected %h actual %h", e.uy, unit_y);
						if (unit_z !== e.uz)
							$error("unit_z expected %h actual %h", e.uz, unit_z);
						if (magnitude !== e.mag)
							$error("magnitude expected %h actual %h", e.mag, magnitude);
						if (zero_vector !== e.zero)
							$error("zero_vector expected %b actual %b", e.zero, zero_vector);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

/* tb/tb_top.sv */
// Testbench top that drives vectors into the normalizer and gives the verdict.
`timescale 1ns / 1ps
module tb_top import nv3_pkg::*;;
	localparam int LATENCY = COORD_BITS_DEF + 36;
	localparam int IDLE_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] comp_x = '0, comp_y = '0, comp_z = '0;
	logic done, zero_vector;
	logic signed [Q_BITS-1:0] unit_x, unit_y, unit_z;
	logic [Q_BITS-1:0] magnitude;
	int fail_count, pending_count;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	normalize_vector_3d uut (.*);
	normalize_vector_3d_checker checker_i (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[normalize_vector_3d] ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] pick_comp();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return $urandom_range(3) - 1;
			4: return 32'($signed($urandom_range(2000)) - 1000);
			5: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// Presents one vector and holds it until the transfer happens.
	task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		gap = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
		if ($urandom_range(3) == 0)
			gap = 0;
		repeat (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		comp_x <= x;
		comp_y <= y;
		comp_z <= z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		logic [31:0] corner[8];
		int waited;
		corner = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0001_0000, 32'hFFFF_0000, 32'h8000_0001};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 8; i++)
			send_vector(corner[i], 0, 0);
		send_vector(0, 32'h8000_0000, 0);
		send_vector(0, 0, 32'h8000_0000);
		send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_vector(1, 1, 1);
		send_vector(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
		send_vector(32'h0003_0000, 32'h0004_0000, 0);
		send_vector(32'hFFFD_0000, 0, 32'hFFFC_0000);
		send_vector(0, 32'h0000_0002, 32'h0000_0003);
		for (int i = 0; i < 1800; i++)
			send_vector(pick_comp(), pick_comp(), pick_comp());
		start <= 1'b0;
		waited = 0;
		while (pending_count != 0 && waited < 20 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("[normalize_vector_3d] OK");
		else
			$display("[normalize_vector_3d] ERROR");
		$finish;
	end
endmodule
